### hdl/nicc_pkg.sv
// ----------------------------------------------------------------------------
// nicc_pkg
// Shared types and constants of the node info command class list parser.
// ----------------------------------------------------------------------------
package nicc_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_CONTROL_MARK   = 2'd0;
  localparam logic [1:0] REG_EXTENDED_START = 2'd1;
  localparam logic [1:0] REG_TARGET_CLASS   = 2'd2;

  localparam logic [7:0]  CONTROL_MARK_RST   = 8'd239;
  localparam logic [7:0]  EXTENDED_START_RST = 8'd241;
  localparam logic [15:0] TARGET_CLASS_RST   = 16'd0;

  // list phase codes
  localparam logic [1:0] PH_SUPPORTED  = 2'd0;
  localparam logic [1:0] PH_CONTROLLED = 2'd1;
  localparam logic [1:0] PH_DONE       = 2'd2;

  localparam int CNT_W = 7;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam int QDEPTH = 2;

  // classified byte handed from front to back
  typedef struct packed {
    logic        class_valid;
    logic [15:0] class_id;
    logic        in_controlled;
    logic        truncated;
    logic        frame_end;
  } event_t;

  // queue handshake between front, queue and back
  typedef struct packed {
    logic valid;
    logic ready;
  } qlink_t;

endpackage

### hdl/node_info_cc_list_parser.sv
// ----------------------------------------------------------------------------
// node_info_cc_list_parser
// Splits a node information frame into command class identifiers.
// ----------------------------------------------------------------------------
// Frame bytes come in on the slave stream, one per transfer, with tlast on
// the frame's last byte. Each completed class (8 bit, or 16 bit when its first
// byte is at or above extended_start) and each frame end produces one
// transfer on the master stream; other bytes produce none. tuser tells a
// class transfer from a bare frame close. The block takes one byte per
// clock while the queue has room: the classifier decides each byte
// combinationally from its own phase/pair state, and a two-entry queue
// feeds the result stage, so a byte is accepted even while a result waits
// to be taken. An event passes the queue, then the output register. The
// user must write configuration (cfg_we/cfg_addr/cfg_wdata) only while no
// frame is in flight; the block itself does not enforce this.
module node_info_cc_list_parser #(
  parameter int MAX_NIF_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  // frame byte stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] frame_byte
  input  logic        s_axis_tlast,   // frame_end
  // class stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] class_id, [16] in_controlled, [17] is_target, [18] target_found,
  // [19] truncated, [26:20] supported_count, [33:27] controlled_count,
  // [39:34] zero
  output logic [39:0] m_axis_tdata,
  output logic        m_axis_tuser,   // class_valid
  output logic        m_axis_tlast    // frame_done
);

  // configuration registers
  logic [7:0]  control_mark;
  logic [7:0]  extended_start;
  logic [15:0] target_class;

  always_ff @(posedge clk) begin
    if (rst) begin
      control_mark   <= nicc_pkg::CONTROL_MARK_RST;
      extended_start <= nicc_pkg::EXTENDED_START_RST;
      target_class   <= nicc_pkg::TARGET_CLASS_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        nicc_pkg::REG_CONTROL_MARK:   control_mark   <= cfg_wdata[7:0];
        nicc_pkg::REG_EXTENDED_START: extended_start <= cfg_wdata[7:0];
        nicc_pkg::REG_TARGET_CLASS:   target_class   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  nicc_pkg::qlink_t  qlink;
  nicc_pkg::event_t  front_ev, head_ev;
  logic              take, emit, pop;

  // stall input only when the queue has no room
  assign s_axis_tready = qlink.ready;
  assign take          = s_axis_tvalid && s_axis_tready;

  nicc_front #(
    .MAX_NIF_BYTES(MAX_NIF_BYTES)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .frame_byte    (s_axis_tdata),
    .frame_end     (s_axis_tlast),
    .control_mark  (control_mark),
    .extended_start(extended_start),
    .emit          (emit),
    .ev            (front_ev)
  );

  nicc_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (emit),
    .push_ev(front_ev),
    .pop    (pop),
    .link   (qlink),
    .head   (head_ev)
  );

  logic                       o_class_valid, o_in_ctl, o_is_target, o_found;
  logic                       o_trunc;
  logic [15:0]                o_class_id;
  logic [nicc_pkg::CNT_W-1:0] o_sup, o_ctl;

  nicc_back u_back (
    .clk              (clk),
    .rst              (rst),
    .q_valid          (qlink.valid),
    .ev               (head_ev),
    .target_class     (target_class),
    .pop              (pop),
    .out_ready        (m_axis_tready),
    .out_valid        (m_axis_tvalid),
    .out_class_valid  (o_class_valid),
    .out_class_id     (o_class_id),
    .out_in_controlled(o_in_ctl),
    .out_is_target    (o_is_target),
    .out_target_found (o_found),
    .out_frame_done   (m_axis_tlast),
    .out_truncated    (o_trunc),
    .out_supported    (o_sup),
    .out_controlled   (o_ctl)
  );

  assign m_axis_tdata = {6'b000000, o_ctl, o_sup, o_trunc, o_found, o_is_target,
                         o_in_ctl, o_class_id};
  assign m_axis_tuser = o_class_valid;

  // ---- assertions ----

  // queue never asked to take an event it has no room for
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    emit |-> qlink.ready)
    else $error("event pushed into full queue");

  // a target hit only for a real class in the supported list, and it sets found
  a_hit_supported: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && o_is_target) |-> (o_class_valid && !o_in_ctl && o_found))
    else $error("target hit outside supported list");

  // truncation only reported on a class-less frame close
  a_trunc_close: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && o_trunc) |-> (m_axis_tlast && !o_class_valid))
    else $error("truncated flag on a non-closing result");

  // an event popped into the output is shown in the next cycle
  a_pop_shows: assert property (@(posedge clk) disable iff (rst)
    pop |=> m_axis_tvalid)
    else $error("popped event not presented");

endmodule

### hdl/nicc_front.sv
// ----------------------------------------------------------------------------
// nicc_front
// Byte classifier: tracks list phase, pair high byte and frame position.
// ----------------------------------------------------------------------------
module nicc_front #(
  parameter int MAX_NIF_BYTES = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            take,          // byte accepted this cycle
  input  logic [7:0]      frame_byte,
  input  logic            frame_end,
  input  logic [7:0]      control_mark,
  input  logic [7:0]      extended_start,
  output logic            emit,          // event produced by this byte
  output nicc_pkg::event_t ev
);

  localparam int PW = $clog2(MAX_NIF_BYTES + 1);
  localparam logic [PW-1:0] POS_MAX = PW'(MAX_NIF_BYTES);

  logic [1:0]    list_phase, list_phase_next;
  logic          pending_high, pending_high_next;
  logic [7:0]    high_byte, high_byte_next;
  logic [PW-1:0] byte_count, byte_count_next;

  always_comb begin
    logic in_window;
    in_window = (byte_count < POS_MAX);
    list_phase_next   = list_phase;
    pending_high_next = pending_high;
    high_byte_next    = high_byte;
    byte_count_next   = in_window ? byte_count + PW'(1) : byte_count;
    ev.class_valid    = 1'b0;
    ev.class_id       = 16'h0000;
    ev.truncated      = 1'b0;
    ev.frame_end      = frame_end;

    if (list_phase != nicc_pkg::PH_DONE) begin
      if (pending_high) begin
        // second byte of a pair, taken as low byte unconditionally
        ev.class_id       = {high_byte, frame_byte};
        ev.class_valid    = 1'b1;
        pending_high_next = 1'b0;
        high_byte_next    = 8'h00;
      end else if (in_window) begin
        if (frame_byte == control_mark) begin
          list_phase_next = list_phase + 2'd1;
        end else if (frame_byte >= extended_start) begin
          if (frame_end) begin
            ev.truncated = 1'b1;
          end else begin
            pending_high_next = 1'b1;
            high_byte_next    = frame_byte;
          end
        end else begin
          ev.class_id    = {8'h00, frame_byte};
          ev.class_valid = 1'b1;
        end
      end
    end else begin
      pending_high_next = 1'b0;
    end

    ev.in_controlled = ev.class_valid ? (list_phase != nicc_pkg::PH_SUPPORTED)
                                      : (list_phase_next != nicc_pkg::PH_SUPPORTED);
    emit = take && (ev.class_valid || frame_end);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      list_phase   <= nicc_pkg::PH_SUPPORTED;
      pending_high <= 1'b0;
      high_byte    <= 8'h00;
      byte_count   <= '0;
    end else if (take) begin
      if (frame_end) begin
        list_phase   <= nicc_pkg::PH_SUPPORTED;
        pending_high <= 1'b0;
        high_byte    <= 8'h00;
        byte_count   <= '0;
      end else begin
        list_phase   <= list_phase_next;
        pending_high <= pending_high_next;
        high_byte    <= high_byte_next;
        byte_count   <= byte_count_next;
      end
    end
  end

endmodule

### hdl/nicc_queue.sv
// ----------------------------------------------------------------------------
// nicc_queue
// Two-entry event queue between classifier and result stage.
// ----------------------------------------------------------------------------
module nicc_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  nicc_pkg::event_t push_ev,
  input  logic             pop,
  output nicc_pkg::qlink_t link,   // valid: entry waiting, ready: room left
  output nicc_pkg::event_t head
);

  localparam int AW = (nicc_pkg::QDEPTH > 1) ? $clog2(nicc_pkg::QDEPTH) : 1;
  localparam int CW = $clog2(nicc_pkg::QDEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(nicc_pkg::QDEPTH);
  localparam logic [AW-1:0] LAST = AW'(nicc_pkg::QDEPTH - 1);

  nicc_pkg::event_t entries [nicc_pkg::QDEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign link.valid = (count != '0);
  assign link.ready = (count != FULL);
  assign head       = entries[rd_ptr];
  assign do_push    = push && link.ready;
  assign do_pop     = pop && link.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_ev;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + AW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

### hdl/nicc_back.sv
// ----------------------------------------------------------------------------
// nicc_back
// Result stage: per-list counts, target match and the output register.
// ----------------------------------------------------------------------------
module nicc_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  input  nicc_pkg::event_t           ev,
  input  logic [15:0]                target_class,
  output logic                       pop,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic                       out_class_valid,
  output logic [15:0]                out_class_id,
  output logic                       out_in_controlled,
  output logic                       out_is_target,
  output logic                       out_target_found,
  output logic                       out_frame_done,
  output logic                       out_truncated,
  output logic [nicc_pkg::CNT_W-1:0] out_supported,
  output logic [nicc_pkg::CNT_W-1:0] out_controlled
);

  logic [nicc_pkg::CNT_W-1:0] supported_total, supported_total_next;
  logic [nicc_pkg::CNT_W-1:0] controlled_total, controlled_total_next;
  logic                       found_flag, found_flag_next;
  logic                       hit;

  assign pop = q_valid && (!out_valid || out_ready);

  always_comb begin
    supported_total_next  = supported_total;
    controlled_total_next = controlled_total;
    found_flag_next       = found_flag;
    hit                   = 1'b0;
    if (ev.class_valid) begin
      if (!ev.in_controlled) begin
        if (supported_total != nicc_pkg::CNT_MAX) begin
          supported_total_next = supported_total + nicc_pkg::CNT_W'(1);
        end
        if (ev.class_id == target_class) begin
          hit             = 1'b1;
          found_flag_next = 1'b1;
        end
      end else if (controlled_total != nicc_pkg::CNT_MAX) begin
        controlled_total_next = controlled_total + nicc_pkg::CNT_W'(1);
      end
    end
  end

  // payload register
  always_ff @(posedge clk) begin
    if (pop) begin
      out_class_valid   <= ev.class_valid;
      out_class_id      <= ev.class_id;
      out_in_controlled <= ev.in_controlled;
      out_is_target     <= hit;
      out_target_found  <= found_flag_next;
      out_frame_done    <= ev.frame_end;
      out_truncated     <= ev.truncated;
      out_supported     <= supported_total_next;
      out_controlled    <= controlled_total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid        <= 1'b0;
      supported_total  <= '0;
      controlled_total <= '0;
      found_flag       <= 1'b0;
    end else begin
      if (pop) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        if (ev.frame_end) begin
          supported_total  <= '0;
          controlled_total <= '0;
          found_flag       <= 1'b0;
        end else begin
          supported_total  <= supported_total_next;
          controlled_total <= controlled_total_next;
          found_flag       <= found_flag_next;
        end
      end
    end
  end

endmodule

### tb/node_info_cc_list_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// node_info_cc_list_parser_tb
// Self-checking bench for the node info command class list parser.
// ----------------------------------------------------------------------------
// Frames go into the byte stream and the class stream is checked field by
// field. A behavioral copy of the parser, written in this file, predicts
// every transfer when its byte is accepted. The bench runs directed frames
// for the list marks, extended pairs, truncation and the byte limit, then
// random frames under changing register settings. Both sides idle in random
// bursts except in the last stretch.
// ----------------------------------------------------------------------------
module node_info_cc_list_parser_tb;

  localparam int MAX_BYTES = 64;

  // one expected transfer on the class stream
  typedef struct {
    logic        class_valid;
    logic [15:0] class_id;
    logic        in_controlled;
    logic        is_target;
    logic        target_found;
    logic        frame_done;
    logic        truncated;
    logic [6:0]  supported_count;
    logic [6:0]  controlled_count;
  } class_rec_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [15:0] cfg_wdata;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] frame_byte
  logic        s_axis_tlast;   // frame_end
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // [15:0] class_id, [16] in_controlled, [17] is_target, [18] target_found,
  // [19] truncated, [26:20] supported_count, [33:27] controlled_count,
  // [39:34] zero
  logic [39:0] m_axis_tdata;
  logic        m_axis_tuser;   // class_valid
  logic        m_axis_tlast;   // frame_done

  node_info_cc_list_parser #(
    .MAX_NIF_BYTES(MAX_BYTES)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  // registers as the parser should see them
  logic [7:0]  mark_reg;
  logic [7:0]  ext_reg;
  logic [15:0] target_reg;

  // per-frame parse state of the prediction
  logic [1:0]  phase;
  logic        pair_open;
  logic [7:0]  pair_high;
  int          frame_pos;
  logic [6:0]  sup_total;
  logic [6:0]  ctl_total;
  logic        found;

  class_rec_t  expected_classes[$];
  int          errors;
  int          bytes_sent;
  bit          src_gaps;
  bit          sink_stalls;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // hard stop, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("node_info_cc_list_parser_tb failed");
    $finish;
  end

  function automatic void clear_frame_state();
    phase     = nicc_pkg::PH_SUPPORTED;
    pair_open = 1'b0;
    pair_high = 8'd0;
    frame_pos = 0;
    sup_total = 7'd0;
    ctl_total = 7'd0;
    found     = 1'b0;
  endfunction

  // Predict the effect of one accepted frame byte; queues the result if the
  // byte completes a class or closes the frame.
  function automatic void parse_byte(input logic [7:0] b, input logic last);
    class_rec_t  r;
    int          pos;
    logic        valid;
    logic        trunc;
    logic        hit;
    logic [15:0] cls;
    logic [1:0]  cls_phase;
    pos       = frame_pos;
    valid     = 1'b0;
    trunc     = 1'b0;
    hit       = 1'b0;
    cls       = 16'd0;
    cls_phase = phase;
    if (frame_pos < MAX_BYTES) frame_pos++;

    if (phase != nicc_pkg::PH_DONE) begin
      if (pair_open) begin
        // second byte of a pair is always data, even if it equals the mark
        cls       = {pair_high, b};
        valid     = 1'b1;
        pair_open = 1'b0;
        pair_high = 8'd0;
      end else if (pos < MAX_BYTES) begin
        if (b == mark_reg) begin
          phase = (phase == nicc_pkg::PH_SUPPORTED) ? nicc_pkg::PH_CONTROLLED
                                                    : nicc_pkg::PH_DONE;
        end else if (b >= ext_reg) begin
          if (last) begin
            trunc = 1'b1;
          end else begin
            pair_open = 1'b1;
            pair_high = b;
          end
        end else begin
          cls   = {8'd0, b};
          valid = 1'b1;
        end
      end
    end else begin
      pair_open = 1'b0;
    end

    if (valid) begin
      if (cls_phase == nicc_pkg::PH_SUPPORTED) begin
        if (sup_total != 7'h7f) sup_total++;
        if (cls == target_reg) begin
          hit   = 1'b1;
          found = 1'b1;
        end
      end else if (ctl_total != 7'h7f) begin
        ctl_total++;
      end
    end

    if (!valid && !last) return;

    r.class_valid      = valid;
    r.class_id         = cls;
    // without a class the flag shows the phase after this byte
    r.in_controlled    = valid ? (cls_phase != nicc_pkg::PH_SUPPORTED)
                               : (phase != nicc_pkg::PH_SUPPORTED);
    r.is_target        = hit;
    r.target_found     = found;
    r.frame_done       = last;
    r.truncated        = trunc;
    r.supported_count  = sup_total;
    r.controlled_count = ctl_total;
    expected_classes.push_back(r);
    if (last) clear_frame_state();
  endfunction

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------
  function automatic void check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    class_rec_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_classes.size() == 0) begin
        $error("class transfer with nothing expected: tdata %h tuser %b tlast %b",
               m_axis_tdata, m_axis_tuser, m_axis_tlast);
        errors++;
      end else begin
        e = expected_classes.pop_front();
        check_field("class_valid", int'(e.class_valid), int'(m_axis_tuser));
        check_field("class_id", int'(e.class_id), int'(m_axis_tdata[15:0]));
        check_field("in_controlled", int'(e.in_controlled), int'(m_axis_tdata[16]));
        check_field("is_target", int'(e.is_target), int'(m_axis_tdata[17]));
        check_field("target_found", int'(e.target_found), int'(m_axis_tdata[18]));
        check_field("truncated", int'(e.truncated), int'(m_axis_tdata[19]));
        check_field("supported_count", int'(e.supported_count),
                    int'(m_axis_tdata[26:20]));
        check_field("controlled_count", int'(e.controlled_count),
                    int'(m_axis_tdata[33:27]));
        check_field("tdata padding", 0, int'(m_axis_tdata[39:34]));
        check_field("frame_done", int'(e.frame_done), int'(m_axis_tlast));
      end
    end
  end

  // receiver: ready drops for bursts of random length while stalls are on
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (sink_stalls && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  // hold the byte stream until every queued class has been taken
  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (expected_classes.size() != 0);
  endtask

  // Send one frame byte; returns at the edge of its transfer.
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (src_gaps && $urandom_range(0, 299) == 0) begin
      wait_results_drained();
    end else if (src_gaps && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    parse_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] frame[$]);
    foreach (frame[i]) send_byte(frame[i], i == frame.size() - 1);
  endtask

  // block is idle once all results are out; the extra cycles cover bytes
  // that are still passing through without a result
  task automatic settle();
    wait_results_drained();
    repeat (4) @(posedge clk);
  endtask

  // only called while the parser is idle
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      nicc_pkg::REG_CONTROL_MARK:   mark_reg   = val[7:0];
      nicc_pkg::REG_EXTENDED_START: ext_reg    = val[7:0];
      nicc_pkg::REG_TARGET_CLASS:   target_reg = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_regs(input logic [15:0] mark, input logic [15:0] ext,
                          input logic [15:0] target);
    write_reg(nicc_pkg::REG_CONTROL_MARK, mark);
    write_reg(nicc_pkg::REG_EXTENDED_START, ext);
    write_reg(nicc_pkg::REG_TARGET_CLASS, target);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // reset register values: mark 0xEF, extended from 0xF1, target 0
  task automatic test_reset_lists();
    // target hit on 0x00, 0xF0 is single-byte, pair in the controlled list,
    // second mark ends parsing, closing byte after it carries no class
    send_frame('{8'h00, 8'h7f, 8'hf0, 8'hef, 8'h21, 8'hf1, 8'h05, 8'hef, 8'h33,
                 8'hf4});
    settle();
  endtask

  task automatic test_pairs_and_marks();
    write_reg(nicc_pkg::REG_TARGET_CLASS, 16'hf2ef);
    // low byte equal to the mark stays data; lone extended byte truncates
    send_frame('{8'hf2, 8'hef, 8'hff, 8'h00, 8'hff});
    settle();
    set_regs(16'h0020, 16'h0010, 16'h000f);
    // mark wins over extended; second mark closes the frame
    send_frame('{8'h0f, 8'h20, 8'h30, 8'h01, 8'h20});
    // a frame of just the mark closes in the controlled list
    send_frame('{8'h20});
    // a frame of one class
    send_frame('{8'h05});
    settle();
  endtask

  task automatic test_reg_extremes();
    set_regs(16'h0000, 16'h0000, 16'hffff);
    send_frame('{8'hff, 8'hff, 8'h00, 8'h80, 8'h00});
    settle();
    set_regs(16'h00ff, 16'h00ff, 16'h0000);
    send_frame('{8'h00, 8'hfe, 8'hff, 8'hff});
    settle();
  endtask

  task automatic test_byte_limit();
    logic [7:0] frame[$];
    set_regs(16'(nicc_pkg::CONTROL_MARK_RST), 16'(nicc_pkg::EXTENDED_START_RST),
             16'hf511);
    // first byte of a pair at the last position in the limit still pairs
    for (int i = 0; i < MAX_BYTES - 1; i++) frame.push_back(8'(i));
    frame.push_back(8'hf5);
    frame.push_back(8'h11);
    frame.push_back(8'h22);
    frame.push_back(8'hef);
    frame.push_back(8'h33);
    send_frame(frame);
    // frame ends on an ignored byte past the limit
    frame.delete();
    for (int i = 0; i < MAX_BYTES; i++) frame.push_back(8'(i + 1));
    frame.push_back(8'h44);
    send_frame(frame);
    settle();
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0:       return mark_reg;
      1, 2:    return 8'($urandom_range(ext_reg, 255));
      3:       return target_reg[15:8];
      4:       return target_reg[7:0];
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_random_frame();
    logic [7:0] frame[$];
    int len;
    len = ($urandom_range(0, 19) == 0) ? int'($urandom_range(60, 80))
                                        : int'($urandom_range(1, 12));
    for (int i = 0; i < len; i++) frame.push_back(pick_byte());
    send_frame(frame);
  endtask

  task automatic pick_random_regs();
    logic [15:0] mark;
    logic [15:0] ext;
    logic [15:0] target;
    mark = 16'($urandom_range(0, 65535));
    ext  = 16'($urandom_range(0, 65535));
    case ($urandom_range(0, 5))
      0: ext[7:0] = 8'h00;
      1: ext[7:0] = 8'hff;
      2: ext[7:0] = 8'($urandom_range(200, 254));
      default: ;
    endcase
    if ($urandom_range(0, 5) == 0) mark[7:0] = $urandom_range(0, 1) ? 8'hff : 8'h00;
    // targets that the frames can actually produce, plus raw ones
    case ($urandom_range(0, 3))
      0: target = {8'h00, 8'($urandom_range(0, 255))};
      1: target = {8'($urandom_range(ext[7:0], 255)), 8'($urandom_range(0, 255))};
      2: target = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
      default: target = 16'($urandom_range(0, 65535));
    endcase
    set_regs(mark, ext, target);
  endtask

  task automatic test_random_frames(input int byte_goal);
    while (bytes_sent < byte_goal) begin
      settle();
      pick_random_regs();
      repeat ($urandom_range(3, 10)) send_random_frame();
    end
    settle();
  endtask

  // last stretch: no idling on either side
  task automatic test_full_rate(input int byte_goal);
    src_gaps    = 1'b0;
    sink_stalls = 1'b0;
    pick_random_regs();
    while (bytes_sent < byte_goal) send_random_frame();
    settle();
  endtask

  initial begin
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_addr      = nicc_pkg::REG_CONTROL_MARK;
    cfg_wdata     = 16'd0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'd0;
    s_axis_tlast  = 1'b0;
    mark_reg      = nicc_pkg::CONTROL_MARK_RST;
    ext_reg       = nicc_pkg::EXTENDED_START_RST;
    target_reg    = nicc_pkg::TARGET_CLASS_RST;
    errors        = 0;
    bytes_sent    = 0;
    src_gaps      = 1'b1;
    sink_stalls   = 1'b1;
    clear_frame_state();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_lists();
    test_pairs_and_marks();
    test_reg_extremes();
    test_byte_limit();
    test_random_frames(850);
    test_full_rate(960);

    repeat (10) @(posedge clk);
    if (errors == 0 && expected_classes.size() == 0) begin
      $display("node_info_cc_list_parser_tb passed");
    end else begin
      $display("node_info_cc_list_parser_tb failed");
    end
    $finish;
  end

endmodule
